// ===== hw/rtl/hex_escape_decode_utf8_check_unit_assert.svh =====
// ----------------------------------------------------------------------------
// hex_escape_decode_utf8_check_unit_assert.svh
// Assertion macros for the hex escape decoder with UTF-8 check. The macros
// use the clk and rst signals of the module that includes this header.
// ----------------------------------------------------------------------------
`ifndef HEX_ESCAPE_DECODE_UTF8_CHECK_UNIT_ASSERT_SVH
`define HEX_ESCAPE_DECODE_UTF8_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HEDU_ASSERT_HOLDS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("hedu assertion failed");
// next-cycle implication
`define HEDU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hedu assertion failed");
`else
`define HEDU_ASSERT_HOLDS(lbl, pre, post)
`define HEDU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/hedu_pkg.sv =====
// ----------------------------------------------------------------------------
// hedu_pkg
// Types, character codes and helper functions shared by the hex escape
// decoder with UTF-8 check.
// ----------------------------------------------------------------------------
package hedu_pkg;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;

  localparam int FLAG_MALFORMED = 0;
  localparam int FLAG_INVALID   = 1;

  localparam int MAX_BEATS = 4;
  localparam int HELD_DEPTH = 3;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_SLASH,
    ESC_X,
    ESC_DIGIT
  } esc_phase_t;

  typedef struct packed {
    esc_phase_t  phase;
    logic [4:0]  hd;
    logic        stopped;
  } esc_state_t;

  typedef struct packed {
    esc_state_t  nxt;
    logic        malformed;
    logic        feed;
    logic [7:0]  feed_byte;
  } esc_res_t;

  typedef struct packed {
    logic [HELD_DEPTH-1:0][7:0] held;
    logic [1:0]                 hc;
    logic [1:0]                 need;
    logic                       closed;
  } utf_state_t;

  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [2:0]                num;
    logic                      has;
    logic                      fin;
    logic [1:0]                flags;
  } group_t;

  // bit 4 set for a non-hex character, else bits 3..0 hold the digit value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  // continuation bytes required after a lead byte, 0 for a bad lead
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] r;
    if (b >= 8'hC2 && b <= 8'hDF) begin
      r = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      r = 2'd2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      r = 2'd3;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hedu_esc.sv =====
// ----------------------------------------------------------------------------
// hedu_esc
// Escape decoder: tracks backslash, 'x' and two digit characters and turns
// them into one byte; plain characters pass as bytes.
// ----------------------------------------------------------------------------
module hedu_esc (
  input  logic [7:0]           char_in,
  input  logic                 is_final,
  input  hedu_pkg::esc_state_t st,
  output hedu_pkg::esc_res_t   res
);

  logic [4:0] dig;

  assign dig = hedu_pkg::hex_digit(char_in);

  always_comb begin
    res           = '0;
    res.nxt       = st;
    res.feed_byte = char_in;
    if (!st.stopped) begin
      case (st.phase)
        hedu_pkg::ESC_NONE: begin
          if (char_in == hedu_pkg::CHAR_NUL) begin
            res.nxt.stopped = 1'b1;
          end else if (char_in == hedu_pkg::CHAR_BSLASH) begin
            res.nxt.phase = hedu_pkg::ESC_SLASH;
          end else begin
            res.feed = 1'b1;
          end
        end
        hedu_pkg::ESC_SLASH: begin
          if (char_in != hedu_pkg::CHAR_X) begin
            res.malformed = 1'b1;
          end else begin
            res.nxt.phase = hedu_pkg::ESC_X;
          end
        end
        hedu_pkg::ESC_X: begin
          if (char_in == hedu_pkg::CHAR_NUL) begin
            res.malformed = 1'b1;
          end else begin
            res.nxt.hd    = dig;
            res.nxt.phase = hedu_pkg::ESC_DIGIT;
          end
        end
        hedu_pkg::ESC_DIGIT: begin
          if (char_in == hedu_pkg::CHAR_NUL) begin
            res.malformed = 1'b1;
          end else begin
            if (dig[4]) begin
              res.feed_byte = 8'hFF;
            end else if (st.hd[4]) begin
              res.feed_byte = {4'hF, dig[3:0]};
            end else begin
              res.feed_byte = {st.hd[3:0], dig[3:0]};
            end
            res.nxt.phase = hedu_pkg::ESC_NONE;
            res.feed      = 1'b1;
          end
        end
        default: begin
          res.nxt.phase = hedu_pkg::ESC_NONE;
        end
      endcase
    end
    // string ends with an escape still open
    if (is_final && !res.nxt.stopped && res.nxt.phase != hedu_pkg::ESC_NONE) begin
      res.malformed = 1'b1;
    end
    if (res.malformed) begin
      res.nxt.phase   = hedu_pkg::ESC_NONE;
      res.nxt.stopped = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/hedu_utf8.sv =====
// ----------------------------------------------------------------------------
// hedu_utf8
// UTF-8 check of decoded bytes: holds a multi-byte sequence until it is
// complete, then releases all of its bytes as one group.
// ----------------------------------------------------------------------------
module hedu_utf8 (
  input  logic                                         feed,
  input  logic [7:0]                                   feed_byte,
  input  logic                                         is_final,
  input  hedu_pkg::utf_state_t                         st,
  output hedu_pkg::utf_state_t                         nxt,
  output logic [2:0]                                   emit_num,
  output logic [hedu_pkg::MAX_BEATS-1:0][7:0]          emit_bytes,
  output logic                                         invalid
);

  logic [7:0] lo;
  logic [7:0] hi;
  logic [1:0] need0;
  logic [1:0] wr_idx;
  logic       fail;

  assign need0  = hedu_pkg::lead_need(feed_byte);
  assign wr_idx = (st.hc == 2'd3) ? 2'd2 : st.hc;

  always_comb begin
    nxt        = st;
    emit_num   = 3'd0;
    emit_bytes = '0;
    fail       = 1'b0;
    lo         = 8'h80;
    hi         = 8'hBF;
    if (st.hc == 2'd1) begin
      case (st.held[0])
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: lo = 8'h80;
      endcase
    end
    if (feed && !st.closed) begin
      if (st.hc == 2'd0) begin
        if (feed_byte == 8'h00) begin
          nxt.closed = 1'b1;
        end else if (!feed_byte[7]) begin
          emit_bytes[0] = feed_byte;
          emit_num      = 3'd1;
        end else if (need0 != 2'd0) begin
          nxt.need    = need0;
          nxt.held[0] = feed_byte;
          nxt.hc      = 2'd1;
        end else begin
          fail = 1'b1;
        end
      end else if (feed_byte < lo || feed_byte > hi) begin
        fail = 1'b1;
      end else if (st.need <= 2'd1) begin
        for (int i = 0; i < hedu_pkg::HELD_DEPTH; i++) begin
          if (i < int'(st.hc)) begin
            emit_bytes[i] = st.held[i];
          end
        end
        emit_bytes[st.hc] = feed_byte;
        emit_num          = {1'b0, st.hc} + 3'd1;
        nxt.hc            = 2'd0;
        nxt.need          = 2'd0;
      end else begin
        nxt.held[wr_idx] = feed_byte;
        nxt.hc           = st.hc + 2'd1;
        nxt.need         = st.need - 2'd1;
      end
    end
    // sequence still pending at the end of the string
    if (is_final && nxt.hc != 2'd0 && !nxt.closed) begin
      fail = 1'b1;
    end
    if (fail) begin
      nxt.hc     = 2'd0;
      nxt.need   = 2'd0;
      nxt.closed = 1'b1;
    end
    invalid = fail;
  end

endmodule

// ===== hw/rtl/hedu_obuf.sv =====
// ----------------------------------------------------------------------------
// hedu_obuf
// Result buffer: holds one group of up to four result beats and sends
// them out one per cycle unless stalled; end flags ride on the last beat.
// ----------------------------------------------------------------------------
`include "hex_escape_decode_utf8_check_unit_assert.svh"

module hedu_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  hedu_pkg::group_t grp,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       byte_out,
  output logic             has_byte,
  output logic             end_of_result,
  output logic             malformed_escape,
  output logic             utf8_invalid
);

  logic [hedu_pkg::MAX_BEATS-1:0][7:0] bytes;
  logic [2:0]                          num;
  logic [1:0]                          pos;
  logic                                has;
  logic                                fin;
  logic [1:0]                          flags;
  logic                                last;

  assign last      = (pos == 2'(num - 3'd1));
  assign out_valid = (num != 3'd0);
  assign free      = !out_valid || (!out_stall && last);

  assign byte_out         = bytes[pos];
  assign has_byte         = has;
  assign end_of_result    = out_valid && fin && last;
  assign malformed_escape = end_of_result && flags[hedu_pkg::FLAG_MALFORMED];
  assign utf8_invalid     = end_of_result && flags[hedu_pkg::FLAG_INVALID];

  always_ff @(posedge clk) begin
    if (rst) begin
      num <= 3'd0;
      pos <= 2'd0;
    end else if (load) begin
      num <= grp.num;
      pos <= 2'd0;
    end else if (out_valid && !out_stall) begin
      if (last) begin
        num <= 3'd0;
        pos <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= grp.bytes;
      has   <= grp.has;
      fin   <= grp.fin;
      flags <= grp.flags;
    end
  end

  `HEDU_ASSERT_HOLDS(a_bare_marker_is_end, out_valid && !has_byte, end_of_result && byte_out == 8'h00)
  `HEDU_ASSERT_HOLDS(a_group_size, out_valid, num <= 3'd4)

endmodule

// ===== hw/rtl/hex_escape_decode_utf8_check_unit.sv =====
// ----------------------------------------------------------------------------
// hex_escape_decode_utf8_check_unit
// Hex escape decoder with UTF-8 check, top level.
// ----------------------------------------------------------------------------
// Takes one character per cycle while in_stall is low and decodes it in a
// single pass between the input register and the result buffer, which
// registers the first result beat of an accepted input beat. A character
// that completes a multi-byte UTF-8 sequence yields up to four result beats
// (held bytes plus itself), sent one per cycle while out_stall is low; the
// output stays busy until all are sent, and the input register meanwhile
// takes further characters but holds one that yields a result. Characters
// that yield no result never wait on the output.
`include "hex_escape_decode_utf8_check_unit_assert.svh"

module hex_escape_decode_utf8_check_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       has_byte,
  output logic       end_of_result,
  output logic       malformed_escape,
  output logic       utf8_invalid
);

  logic       inq_valid;
  logic [7:0] inq_char;
  logic       inq_final;

  hedu_pkg::esc_state_t esc_st;
  hedu_pkg::utf_state_t utf_st;
  logic [1:0]           err;

  hedu_pkg::esc_res_t                          esc_res;
  hedu_pkg::utf_state_t                        utf_next;
  logic [2:0]                                  emit_num;
  logic [hedu_pkg::MAX_BEATS-1:0][7:0]         emit_bytes;
  logic                                        invalid;
  logic [1:0]                                  err_next;
  hedu_pkg::group_t                            grp;
  logic                                        buf_free;
  logic                                        produce;
  logic                                        adv;
  logic                                        load;

  hedu_esc u_esc (
    .char_in  (inq_char),
    .is_final (inq_final),
    .st       (esc_st),
    .res      (esc_res)
  );

  hedu_utf8 u_utf8 (
    .feed       (esc_res.feed),
    .feed_byte  (esc_res.feed_byte),
    .is_final   (inq_final),
    .st         (utf_st),
    .nxt        (utf_next),
    .emit_num   (emit_num),
    .emit_bytes (emit_bytes),
    .invalid    (invalid)
  );

  assign err_next = err | {invalid, esc_res.malformed};

  assign produce = (emit_num != 3'd0) || inq_final;
  assign adv     = inq_valid && (buf_free || !produce);
  assign load    = adv && produce;
  assign in_stall = inq_valid && !adv;

  always_comb begin
    grp.bytes = emit_bytes;
    grp.num   = (emit_num != 3'd0) ? emit_num : 3'd1;
    grp.has   = (emit_num != 3'd0);
    grp.fin   = inq_final;
    grp.flags = err_next;
  end

  hedu_obuf u_obuf (
    .clk              (clk),
    .rst              (rst),
    .load             (load),
    .grp              (grp),
    .free             (buf_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_out         (byte_out),
    .has_byte         (has_byte),
    .end_of_result    (end_of_result),
    .malformed_escape (malformed_escape),
    .utf8_invalid     (utf8_invalid)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (!in_stall) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      inq_char  <= char_in;
      inq_final <= is_final;
    end
  end

  // decoder state; all but the held bytes return to reset after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      esc_st        <= '0;
      utf_st.hc     <= 2'd0;
      utf_st.need   <= 2'd0;
      utf_st.closed <= 1'b0;
      err           <= 2'd0;
    end else if (adv) begin
      utf_st.held <= utf_next.held;
      if (inq_final) begin
        esc_st        <= '0;
        utf_st.hc     <= 2'd0;
        utf_st.need   <= 2'd0;
        utf_st.closed <= 1'b0;
        err           <= 2'd0;
      end else begin
        esc_st        <= esc_res.nxt;
        utf_st.hc     <= utf_next.hc;
        utf_st.need   <= utf_next.need;
        utf_st.closed <= utf_next.closed;
        err           <= err_next;
      end
    end
  end

  `HEDU_ASSERT_HOLDS(a_held_needs_more, utf_st.hc != 2'd0, utf_st.need != 2'd0)
  `HEDU_ASSERT_HOLDS(a_closed_holds_none, utf_st.closed, utf_st.hc == 2'd0)
  `HEDU_ASSERT_NEXT(a_final_clears_esc, adv && inq_final, esc_st == '0 && err == 2'd0)
  `HEDU_ASSERT_NEXT(a_final_clears_utf, adv && inq_final, utf_st.hc == 2'd0 && !utf_st.closed)

endmodule

// ===== dv/hedu_result_checker.sv =====
// ----------------------------------------------------------------------------
// hedu_result_checker
// Watches both channels of the hex escape decoder with UTF-8 check. Each
// accepted character runs through a local decoder and UTF-8 validator that
// yields the beats the block must send. Each accepted output beat is compared
// with the oldest pending beat. Mismatches and unexpected beats are counted
// and handed to the testbench top.
// ----------------------------------------------------------------------------
module hedu_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       is_final,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] byte_out,
  input  logic       has_byte,
  input  logic       end_of_result,
  input  logic       malformed_escape,
  input  logic       utf8_invalid,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       mal;
    logic       inv;
  } beat_t;

  beat_t      pending_beats[$];
  logic [7:0] step_bytes[$];
  beat_t      got;
  beat_t      want;

  hedu_pkg::esc_phase_t phase;
  logic [4:0] first_digit;
  logic [7:0] seq_bytes[hedu_pkg::HELD_DEPTH];
  int         seq_held;
  int         seq_need;
  bit         stopped;
  bit         closed;
  logic [1:0] err;

  function automatic int nibble_of(input logic [7:0] c);
    int v;
    v = -1;
    if (c >= "0" && c <= "9") begin
      v = int'(c) - 48;
    end else if (c >= "a" && c <= "f") begin
      v = int'(c) - 97 + 10;
    end else if (c >= "A" && c <= "F") begin
      v = int'(c) - 65 + 10;
    end
    return v;
  endfunction

  task automatic clear_string();
    phase = hedu_pkg::ESC_NONE;
    first_digit = '0;
    seq_held = 0;
    seq_need = 0;
    stopped = 1'b0;
    closed = 1'b0;
    err = '0;
  endtask

  task automatic seq_abort();
    seq_held = 0;
    seq_need = 0;
    closed = 1'b1;
    err[hedu_pkg::FLAG_INVALID] = 1'b1;
  endtask

  task automatic bad_escape();
    phase = hedu_pkg::ESC_NONE;
    stopped = 1'b1;
    err[hedu_pkg::FLAG_MALFORMED] = 1'b1;
  endtask

  task automatic utf8_push(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (closed) begin
      // output already shut, byte dropped
    end else if (seq_held == 0) begin
      if (b == 8'h00) begin
        closed = 1'b1;
      end else if (b < 8'h80) begin
        step_bytes.push_back(b);
      end else begin
        if (b >= 8'hC2 && b <= 8'hDF) begin
          seq_need = 1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          seq_need = 2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          seq_need = 3;
        end else begin
          seq_need = 0;
        end
        if (seq_need == 0) begin
          seq_abort();
        end else begin
          seq_bytes[0] = b;
          seq_held = 1;
        end
      end
    end else begin
      if (seq_held == 1) begin
        case (seq_bytes[0])
          8'hE0: lo = 8'hA0;
          8'hED: hi = 8'h9F;
          8'hF0: lo = 8'h90;
          8'hF4: hi = 8'h8F;
          default: ;
        endcase
      end
      if (b < lo || b > hi) begin
        seq_abort();
      end else if (seq_need <= 1) begin
        for (int i = 0; i < seq_held; i++) begin
          step_bytes.push_back(seq_bytes[i]);
        end
        step_bytes.push_back(b);
        seq_held = 0;
        seq_need = 0;
      end else begin
        seq_bytes[seq_held] = b;
        seq_held++;
        seq_need--;
      end
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    int         v;
    logic [7:0] b;
    beat_t      beat;
    step_bytes.delete();
    if (!stopped) begin
      case (phase)
        hedu_pkg::ESC_NONE: begin
          if (c == hedu_pkg::CHAR_NUL) begin
            stopped = 1'b1;
          end else if (c == hedu_pkg::CHAR_BSLASH) begin
            phase = hedu_pkg::ESC_SLASH;
          end else begin
            utf8_push(c);
          end
        end
        hedu_pkg::ESC_SLASH: begin
          if (c != hedu_pkg::CHAR_X) begin
            bad_escape();
          end else begin
            phase = hedu_pkg::ESC_X;
          end
        end
        hedu_pkg::ESC_X: begin
          if (c == hedu_pkg::CHAR_NUL) begin
            bad_escape();
          end else begin
            v = nibble_of(c);
            first_digit = (v < 0) ? 5'h10 : {1'b0, v[3:0]};
            phase = hedu_pkg::ESC_DIGIT;
          end
        end
        default: begin
          if (c == hedu_pkg::CHAR_NUL) begin
            bad_escape();
          end else begin
            v = nibble_of(c);
            if (v < 0) begin
              b = 8'hFF;
            end else if (first_digit[4]) begin
              b = {4'hF, v[3:0]};
            end else begin
              b = {first_digit[3:0], v[3:0]};
            end
            phase = hedu_pkg::ESC_NONE;
            utf8_push(b);
          end
        end
      endcase
    end
    if (fin) begin
      if (!stopped && phase != hedu_pkg::ESC_NONE) begin
        bad_escape();
      end
      if (seq_held != 0 && !closed) begin
        seq_abort();
      end
      if (step_bytes.size() == 0) begin
        beat = '0;
        beat.last = 1'b1;
        beat.mal = err[hedu_pkg::FLAG_MALFORMED];
        beat.inv = err[hedu_pkg::FLAG_INVALID];
        pending_beats.push_back(beat);
      end
    end
    foreach (step_bytes[i]) begin
      beat = '0;
      beat.data = step_bytes[i];
      beat.has = 1'b1;
      if (fin && i == step_bytes.size() - 1) begin
        beat.last = 1'b1;
        beat.mal = err[hedu_pkg::FLAG_MALFORMED];
        beat.inv = err[hedu_pkg::FLAG_INVALID];
      end
      pending_beats.push_back(beat);
    end
    if (fin) begin
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      pending_beats.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_char(char_in, is_final);
      end
      if (out_valid && !out_stall) begin
        got.data = byte_out;
        got.has = has_byte;
        got.last = end_of_result;
        got.mal = malformed_escape;
        got.inv = utf8_invalid;
        if (pending_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected beat: data %h has %b last %b mal %b inv %b",
                     got.data, got.has, got.last, got.mal, got.inv);
          end
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("beat mismatch: exp data %h has %b last %b mal %b inv %b",
                       want.data, want.has, want.last, want.mal, want.inv);
              $display("               got data %h has %b last %b mal %b inv %b",
                       got.data, got.has, got.last, got.mal, got.inv);
            end
          end
        end
      end
    end
    outstanding = pending_beats.size();
  end

endmodule

// ===== dv/hex_escape_decode_utf8_check_unit_test.sv =====
// ----------------------------------------------------------------------------
// hex_escape_decode_utf8_check_unit_test
// Drives encoded strings into the hex escape decoder with UTF-8 check: a
// short directed set of escape and sequence corner cases, then random
// strings built mostly from valid code points with random escaping, mixed
// with noise, broken escapes, zeros and cut or damaged sequences. The
// sender runs in bursts, the receiver stalls on its own pattern, and a
// checker beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module hex_escape_decode_utf8_check_unit_test;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic       is_final = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] byte_out;
  logic       has_byte;
  logic       end_of_result;
  logic       malformed_escape;
  logic       utf8_invalid;

  int         fail_count;
  int         outstanding;
  int         burst_left = 0;
  int         chars_sent = 0;
  bit         hold_request = 1'b0;
  logic [7:0] text[$];

  always #10 clk = ~clk;

  hex_escape_decode_utf8_check_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .char_in          (char_in),
    .is_final         (is_final),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_out         (byte_out),
    .has_byte         (has_byte),
    .end_of_result    (end_of_result),
    .malformed_escape (malformed_escape),
    .utf8_invalid     (utf8_invalid)
  );

  hedu_result_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .char_in          (char_in),
    .is_final         (is_final),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_out         (byte_out),
    .has_byte         (has_byte),
    .end_of_result    (end_of_result),
    .malformed_escape (malformed_escape),
    .utf8_invalid     (utf8_invalid),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // receiver: stall mode picked at random for a random span; long hold on request
  initial begin : rx_stall
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 90;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic put_char(input logic [7:0] c, input logic fin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    char_in <= c;
    is_final <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_text();
    foreach (text[i]) begin
      put_char(text[i], i == text.size() - 1);
    end
    chars_sent += text.size();
    text.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    burst_left = 0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  task automatic add_byte(input logic [7:0] b, input bit escaped);
    if (escaped) begin
      text.push_back(hedu_pkg::CHAR_BSLASH);
      text.push_back(hedu_pkg::CHAR_X);
      text.push_back(hex_char(b[7:4]));
      text.push_back(hex_char(b[3:0]));
    end else begin
      text.push_back(b);
    end
  endtask

  // style 0: whole code point, 1: cut short, 2: one continuation damaged
  task automatic add_codepoint(input int style);
    logic [20:0] cp;
    logic [7:0]  enc[$];
    int          keep;
    bit          at_limit;
    at_limit = ($urandom_range(0, 3) == 0);
    case ($urandom_range(1, 3))
      1: begin
        cp = at_limit ? ($urandom_range(0, 1) ? 21'h80 : 21'h7FF)
                      : 21'($urandom_range(12'h080, 12'h7FF));
        enc.push_back(8'hC0 | cp[10:6]);
        enc.push_back(8'h80 | cp[5:0]);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: cp = 21'h0800;
          1: cp = 21'hD7FF;
          2: cp = 21'hE000;
          default: cp = 21'hFFFF;
        endcase
        if (!at_limit) begin
          cp = 21'($urandom_range(16'h0800, 16'hFFFF));
        end
        if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
          cp = cp ^ 21'h4000;
        end
        enc.push_back(8'hE0 | cp[15:12]);
        enc.push_back(8'h80 | cp[11:6]);
        enc.push_back(8'h80 | cp[5:0]);
      end
      default: begin
        cp = at_limit ? ($urandom_range(0, 1) ? 21'h10000 : 21'h10FFFF)
                      : 21'($urandom_range(21'h10000, 21'h10FFFF));
        enc.push_back(8'hF0 | cp[20:18]);
        enc.push_back(8'h80 | cp[17:12]);
        enc.push_back(8'h80 | cp[11:6]);
        enc.push_back(8'h80 | cp[5:0]);
      end
    endcase
    keep = enc.size();
    if (style == 1) begin
      keep = $urandom_range(1, enc.size() - 1);
    end else if (style == 2) begin
      enc[$urandom_range(1, enc.size() - 1)] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < keep; i++) begin
      add_byte(enc[i], $urandom_range(0, 1) != 0);
    end
  endtask

  task automatic add_token();
    int          pick;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == hedu_pkg::CHAR_BSLASH) begin
        c = "_";
      end
      add_byte(c, $urandom_range(0, 3) == 0);
    end else if (pick < 70) begin
      add_codepoint(0);
    end else if (pick < 76) begin
      text.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 85) begin
      add_byte(8'h00, $urandom_range(0, 1) != 0);
    end else if (pick < 89) begin
      add_codepoint(1);
    end else if (pick < 92) begin
      add_codepoint(2);
    end else if (pick < 96) begin
      // broken escape: wrong char after backslash, or a zero digit
      text.push_back(hedu_pkg::CHAR_BSLASH);
      if ($urandom_range(0, 1)) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        text.push_back(hedu_pkg::CHAR_X);
        if ($urandom_range(0, 1)) begin
          text.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        text.push_back(hedu_pkg::CHAR_NUL);
      end
    end else begin
      // escape with arbitrary digit characters
      text.push_back(hedu_pkg::CHAR_BSLASH);
      text.push_back(hedu_pkg::CHAR_X);
      text.push_back(8'($urandom_range(1, 255)));
      text.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    bit held_off;
    held_off = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // two-byte sequence from escapes, mixed-case digits
    text = '{hedu_pkg::CHAR_BSLASH, hedu_pkg::CHAR_X, "c", "3",
             hedu_pkg::CHAR_BSLASH, hedu_pkg::CHAR_X, "A", "9"};
    send_text();
    // bad first digit, sequence left open at the end
    text = '{hedu_pkg::CHAR_BSLASH, hedu_pkg::CHAR_X, "q", "1"};
    send_text();
    // bad second digit
    text = '{hedu_pkg::CHAR_BSLASH, hedu_pkg::CHAR_X, "4", "z"};
    send_text();
    // backslash not followed by x
    text = '{hedu_pkg::CHAR_BSLASH, "y"};
    send_text();
    text = '{8'hFF};
    send_text();
    // raw zero ends the content
    text = '{"a", hedu_pkg::CHAR_NUL, "b"};
    send_text();
    // string ends with an escape open
    text = '{hedu_pkg::CHAR_BSLASH, hedu_pkg::CHAR_X};
    send_text();
    drain();

    chars_sent = 0;
    while (chars_sent < 330) begin
      if (!held_off && chars_sent > 120) begin
        hold_request = 1'b1;
        burst_left = 100;
        held_off = 1'b1;
      end
      repeat ($urandom_range(1, 8)) add_token();
      send_text();
      if ($urandom_range(0, 15) == 0) begin
        drain();
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
